>>> src/iair_pkg.sv
// ---------------------------------------------------------------------------
// iair_pkg
// Shared request codes, status codes and field widths of the ordered array.
// ---------------------------------------------------------------------------
package iair_pkg;

   // Field widths of the request and response beats
   localparam int unsigned REQ_TYPE_W = 4;
   localparam int unsigned INDEX_W    = 6;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned COUNT_W    = 7;
   localparam int unsigned STATUS_W   = 2;

   // Width used to compare index and count without overflow
   localparam int unsigned CMP_W      = 16;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_APPEND       = 4'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PREPEND      = 4'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT       = 4'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SWAP_REMOVE  = 4'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_STABLE_REM   = 4'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE_FIRST = 4'd5;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE_LAST  = 4'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR        = 4'd7;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ         = 4'd8;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ_LAST    = 4'd9;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

endpackage

>>> src/iair_ram.sv
// ---------------------------------------------------------------------------
// iair_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ---------------------------------------------------------------------------
module iair_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/indexed_array_insert_remove.sv
// ---------------------------------------------------------------------------
// indexed_array_insert_remove
// Fixed-capacity ordered array with insert, remove, clear and read requests.
// ---------------------------------------------------------------------------
// The block keeps up to DEPTH elements of ELEM_WIDTH bits in order, in one
// synchronous RAM with registered read data. Each request beat yields
// exactly one response beat carrying the read data (zero unless a
// successful read), the element count after the request and a status (ok,
// full refused, or empty / index out of range / unknown request). Requests
// are handled one at a time. Insert, prepend, stable remove and remove
// first shift the elements between the index and the tail; swap remove
// moves the tail element into the hole. The shifts stream one element per
// cycle through the RAM, reading one entry while writing the one read in
// the previous cycle, so the single RAM write port sets the pace. A new
// request beat is taken once the previous response is loaded into the
// response register, even while that response is still stalled.
// ---------------------------------------------------------------------------
module indexed_array_insert_remove #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned ELEM_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,

   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [iair_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [iair_pkg::INDEX_W-1:0]       req_index,
   input  logic [iair_pkg::DATA_W-1:0]        req_elem_data,

   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [iair_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [iair_pkg::COUNT_W-1:0]       rsp_elem_count,
   output logic [iair_pkg::STATUS_W-1:0]      rsp_status
);

   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W  = iair_pkg::CMP_W;

   // Sequencer states
   typedef enum logic [5:0] {
      IDLE       = 6'b000001,
      SHIFT_UP   = 6'b000010,
      PUT        = 6'b000100,
      SHIFT_DOWN = 6'b001000,
      SWAP       = 6'b010000,
      DONE       = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [iair_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                            rd_sel_ff, rd_sel_in;
   logic [ADDR_W-1:0]               ptr_ff, ptr_in;
   logic [ADDR_W-1:0]               stop_ff, stop_in;
   logic [ELEM_WIDTH-1:0]           data_ff, data_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [iair_pkg::DATA_W-1:0]     rsp_read_data_ff, rsp_read_data_in;
   logic [iair_pkg::COUNT_W-1:0]    rsp_elem_count_ff, rsp_elem_count_in;
   logic [iair_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   // RAM ports
   logic                            ram_we;
   logic [ADDR_W-1:0]               ram_waddr;
   logic [ELEM_WIDTH-1:0]           ram_wdata;
   logic                            ram_re;
   logic [ADDR_W-1:0]               ram_raddr;
   logic [ELEM_WIDTH-1:0]           ram_rdata;

   // Widened views for compares and data width adaption
   logic [CMP_W-1:0]                count_wide;
   logic [CMP_W-1:0]                idx_wide;
   logic [CMP_W-1:0]                ins_pos;
   logic [CMP_W-1:0]                rem_pos;
   logic [ADDR_W-1:0]               last_addr;
   logic                            full;
   logic [63:0]                     req_data_wide;
   logic [63:0]                     rd_wide;

   iair_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      count_wide    = CMP_W'(count_ff);
      idx_wide      = CMP_W'(req_index);
      last_addr     = ADDR_W'(count_wide - CMP_W'(1));
      full          = (count_wide == CMP_W'(DEPTH));
      req_data_wide = 64'(req_elem_data);
      rd_wide       = '0;
      rd_wide[ELEM_WIDTH-1:0] = ram_rdata;
      // Prepend inserts at the head, remove first removes at the head
      ins_pos = (req_type == iair_pkg::REQ_PREPEND) ? '0 : idx_wide;
      rem_pos = (req_type == iair_pkg::REQ_REMOVE_FIRST) ? '0 : idx_wide;
   end

   // Sequencer: decode on the request beat, stream shifts, then respond
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      status_in         = status_ff;
      rd_sel_in         = rd_sel_ff;
      ptr_in            = ptr_ff;
      stop_in           = stop_ff;
      data_in           = data_ff;
      rsp_valid_in      = rsp_valid_ff & rsp_stall;
      rsp_read_data_in  = rsp_read_data_ff;
      rsp_elem_count_in = rsp_elem_count_ff;
      rsp_status_in     = rsp_status_ff;
      ram_we            = 1'b0;
      ram_waddr         = '0;
      ram_wdata         = '0;
      ram_re            = 1'b0;
      ram_raddr         = '0;

      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               status_in = iair_pkg::STAT_OK;
               rd_sel_in = 1'b0;
               state_in  = DONE;
               data_in   = req_data_wide[ELEM_WIDTH-1:0];
               case (req_type)
                  iair_pkg::REQ_APPEND: begin
                     if (full) begin
                        status_in = iair_pkg::STAT_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_wide[ADDR_W-1:0];
                        ram_wdata = req_data_wide[ELEM_WIDTH-1:0];
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  iair_pkg::REQ_PREPEND, iair_pkg::REQ_INSERT: begin
                     if (full) begin
                        status_in = iair_pkg::STAT_FULL;
                     end else if (ins_pos > count_wide) begin
                        status_in = iair_pkg::STAT_RANGE;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        if (ins_pos == count_wide) begin
                           // Insert at the end: plain append
                           ram_we    = 1'b1;
                           ram_waddr = count_wide[ADDR_W-1:0];
                           ram_wdata = req_data_wide[ELEM_WIDTH-1:0];
                        end else begin
                           // Start moving elements up from the tail
                           ram_re    = 1'b1;
                           ram_raddr = last_addr;
                           ptr_in    = last_addr;
                           stop_in   = ins_pos[ADDR_W-1:0];
                           state_in  = SHIFT_UP;
                        end
                     end
                  end
                  iair_pkg::REQ_SWAP_REMOVE: begin
                     if (idx_wide >= count_wide) begin
                        status_in = iair_pkg::STAT_RANGE;
                     end else begin
                        // Fetch the tail, drop it into the hole next cycle
                        ram_re    = 1'b1;
                        ram_raddr = last_addr;
                        stop_in   = idx_wide[ADDR_W-1:0];
                        count_in  = count_ff - CNT_W'(1);
                        state_in  = SWAP;
                     end
                  end
                  iair_pkg::REQ_STABLE_REM, iair_pkg::REQ_REMOVE_FIRST: begin
                     if (rem_pos >= count_wide) begin
                        status_in = iair_pkg::STAT_RANGE;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        if (rem_pos + CMP_W'(1) != count_wide) begin
                           // Start moving elements down from the hole
                           ram_re    = 1'b1;
                           ram_raddr = ADDR_W'(rem_pos + CMP_W'(1));
                           ptr_in    = ADDR_W'(rem_pos + CMP_W'(1));
                           stop_in   = last_addr;
                           state_in  = SHIFT_DOWN;
                        end
                     end
                  end
                  iair_pkg::REQ_REMOVE_LAST: begin
                     if (count_wide == '0) begin
                        status_in = iair_pkg::STAT_RANGE;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  iair_pkg::REQ_CLEAR: begin
                     count_in = '0;
                  end
                  iair_pkg::REQ_READ: begin
                     if (idx_wide >= count_wide) begin
                        status_in = iair_pkg::STAT_RANGE;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_wide[ADDR_W-1:0];
                        rd_sel_in = 1'b1;
                     end
                  end
                  iair_pkg::REQ_READ_LAST: begin
                     if (count_wide == '0) begin
                        status_in = iair_pkg::STAT_RANGE;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = last_addr;
                        rd_sel_in = 1'b1;
                     end
                  end
                  default: begin
                     status_in = iair_pkg::STAT_RANGE;
                  end
               endcase
            end
         end

         SHIFT_UP: begin
            // Write the element read last cycle one place up
            ram_we    = 1'b1;
            ram_waddr = ptr_ff + ADDR_W'(1);
            ram_wdata = ram_rdata;
            if (ptr_ff == stop_ff) begin
               state_in = PUT;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff - ADDR_W'(1);
               ptr_in    = ptr_ff - ADDR_W'(1);
            end
         end

         PUT: begin
            // Fill the opened gap with the new element
            ram_we    = 1'b1;
            ram_waddr = stop_ff;
            ram_wdata = data_ff;
            state_in  = DONE;
         end

         SHIFT_DOWN: begin
            // Write the element read last cycle one place down
            ram_we    = 1'b1;
            ram_waddr = ptr_ff - ADDR_W'(1);
            ram_wdata = ram_rdata;
            if (ptr_ff == stop_ff) begin
               state_in = DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff + ADDR_W'(1);
               ptr_in    = ptr_ff + ADDR_W'(1);
            end
         end

         SWAP: begin
            ram_we    = 1'b1;
            ram_waddr = stop_ff;
            ram_wdata = ram_rdata;
            state_in  = DONE;
         end

         DONE: begin
            // Load the response register once it is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_read_data_in  = rd_sel_ff ? rd_wide[iair_pkg::DATA_W-1:0] : '0;
               rsp_elem_count_in = count_wide[iair_pkg::COUNT_W-1:0];
               rsp_status_in     = status_ff;
               state_in          = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers: no reset needed
   always_ff @(posedge clock) begin
      status_ff         <= status_in;
      rd_sel_ff         <= rd_sel_in;
      ptr_ff            <= ptr_in;
      stop_ff           <= stop_in;
      data_ff           <= data_in;
      rsp_read_data_ff  <= rsp_read_data_in;
      rsp_elem_count_ff <= rsp_elem_count_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign req_stall      = (state_ff != IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_elem_count = rsp_elem_count_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
